@@ rtl/core/hsvr_pkg.sv @@
// Shared types, constants and helper functions for the rainbow HSV to RGB converter.
`default_nettype none

package hsvr_pkg;

  // Hue section layout and ramp levels.
  localparam logic [4:0] OfsMask   = 5'h1F;
  localparam logic [7:0] K255      = 8'd255;
  localparam logic [7:0] K171      = 8'd171;
  localparam logic [7:0] K85       = 8'd85;
  localparam logic [7:0] OneThird  = 8'(256 / 3);
  localparam logic [7:0] TwoThirds = 8'((256 * 2) / 3);

  // Hue section codes, taken from the top three hue bits.
  typedef enum logic [2:0] {
    SecRedOrange   = 3'd0,
    SecOrangeYel   = 3'd1,
    SecYelGreen    = 3'd2,
    SecGreenAqua   = 3'd3,
    SecAquaBlue    = 3'd4,
    SecBluePurple  = 3'd5,
    SecPurplePink  = 3'd6,
    SecPinkRed     = 3'd7
  } hue_sec_e;

  // One colour triple as it moves between modules and stages.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Upper byte of an 8 by 8 product.
  function automatic logic [7:0] mul_hi8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = 16'(a) * 16'(b);
    return prod[15:8];
  endfunction

  // Video scaling: zero stays zero, and a nonzero channel stays nonzero
  // as long as the scale is nonzero.
  function automatic logic [7:0] video_chan(input logic [7:0] c, input logic [7:0] scale);
    logic [7:0] res;
    if (c == 8'd0) begin
      res = 8'd0;
    end else begin
      res = mul_hi8(c, scale) + ((scale != 8'd0) ? 8'd1 : 8'd0);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsvr_hsv_if.sv @@
// Channel interface that carries one hue, saturation and brightness item.
`default_nettype none

interface hsvr_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/hsvr_rgb_if.sv @@
// Channel interface that carries one red, green and blue item.
`default_nettype none

interface hsvr_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hsvr_hue_map.sv @@
// Eight-section rainbow hue map with moderate yellow boost, fully saturated colour.
`default_nettype none

module hsvr_hue_map
  import hsvr_pkg::*;
(
  input  wire logic [7:0] hue_i,
  output rgb_t            rgb_o
);

  logic [7:0] pos;
  logic [7:0] third;
  logic [7:0] twoth;
  hue_sec_e   sec;

  // Ramp position inside the section and its one-third and two-thirds ramps.
  assign pos   = {hue_i[4:0] & OfsMask, 3'b000};
  assign third = mul_hi8(pos, OneThird);
  assign twoth = mul_hi8(pos, TwoThirds);
  assign sec   = hue_sec_e'(hue_i[7:5]);

  // Section select of the three channel levels.
  always_comb begin
    rgb_o = '0;
    case (sec)
      SecRedOrange: begin
        rgb_o.red = K255 - third; rgb_o.green = third; rgb_o.blue = 8'd0;
      end
      SecOrangeYel: begin
        rgb_o.red = K171; rgb_o.green = K85 + third; rgb_o.blue = 8'd0;
      end
      SecYelGreen: begin
        rgb_o.red = K171 - twoth; rgb_o.green = K171 + third; rgb_o.blue = 8'd0;
      end
      SecGreenAqua: begin
        rgb_o.red = 8'd0; rgb_o.green = K255 - third; rgb_o.blue = third;
      end
      SecAquaBlue: begin
        rgb_o.red = 8'd0; rgb_o.green = K171 - twoth; rgb_o.blue = K85 + twoth;
      end
      SecBluePurple: begin
        rgb_o.red = third; rgb_o.green = 8'd0; rgb_o.blue = K255 - third;
      end
      SecPurplePink: begin
        rgb_o.red = K85 + third; rgb_o.green = 8'd0; rgb_o.blue = K171 - third;
      end
      SecPinkRed: begin
        rgb_o.red = K171 + third; rgb_o.green = 8'd0; rgb_o.blue = K85 - third;
      end
      default: begin
        rgb_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb_rainbow_top.sv @@
// Top level of the rainbow HSV to RGB converter: a three-stage pipeline.
//
// Usage:
//   The hsv_i channel takes one hue, saturation and brightness item per cycle;
//   the rgb_o channel returns one red, green and blue item for each of them,
//   in order. Both channels use valid and ready; an item moves on a rising
//   edge at which both are high.
//   The result is registered in stages one, two and three and is shown on rgb_o
//   from the stage three register until a ready receiver takes it. Stage
//   one does the hue map and the floor and squared-value products, stage two
//   the saturation scaling, stage three the value scaling, which is also the
//   output register.
//   Throughput is one item per cycle. The three stages advance together on
//   one enable that is high whenever the output register is empty or its
//   item is being taken, so a stalled receiver freezes every stage and
//   holds hsv_i.ready low; nothing is lost or repeated.
//   Reset clears all stage valid bits; the block accepts items in the first
//   cycle after reset is released.
`default_nettype none

module hsv_to_rgb_rainbow_top
  import hsvr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsvr_hsv_if.sink   hsv_i,
  hsvr_rgb_if.source rgb_o
);

  logic adv;

  logic       s1_valid_q, s2_valid_q, s3_valid_q;
  rgb_t       map_rgb;
  rgb_t       s1_rgb_q, s2_rgb_q, s3_rgb_q;
  rgb_t       s2_rgb_d, s3_rgb_d;
  logic [7:0] s1_floor_q, s1_sat_q, s1_v2_q, s2_v2_q;
  logic       s1_sfull_q, s1_vfull_q, s2_vfull_q;
  logic [7:0] floor_d, v2_d;

  // Whole pipeline advances when the output slot is free or being drained.
  assign adv         = !s3_valid_q || rgb_o.ready;
  assign hsv_i.ready = adv;

  // Stage one: hue map, desaturation floor and video-squared brightness.
  hsvr_hue_map u_hue_map (
    .hue_i (hsv_i.hue),
    .rgb_o (map_rgb)
  );

  assign floor_d = mul_hi8(K255 - hsv_i.saturation, K255 - hsv_i.saturation);
  assign v2_d    = mul_hi8(hsv_i.brightness, hsv_i.brightness)
                   + ((hsv_i.brightness != 8'd0) ? 8'd1 : 8'd0);

  // Stage two: saturation scaling plus floor with 8-bit wrap.
  always_comb begin
    if (s1_sfull_q) begin
      s2_rgb_d = s1_rgb_q;
    end else begin
      s2_rgb_d.red   = video_chan(s1_rgb_q.red,   s1_sat_q) + s1_floor_q;
      s2_rgb_d.green = video_chan(s1_rgb_q.green, s1_sat_q) + s1_floor_q;
      s2_rgb_d.blue  = video_chan(s1_rgb_q.blue,  s1_sat_q) + s1_floor_q;
    end
  end

  // Stage three: brightness scaling.
  always_comb begin
    if (s2_vfull_q) begin
      s3_rgb_d = s2_rgb_q;
    end else begin
      s3_rgb_d.red   = video_chan(s2_rgb_q.red,   s2_v2_q);
      s3_rgb_d.green = video_chan(s2_rgb_q.green, s2_v2_q);
      s3_rgb_d.blue  = video_chan(s2_rgb_q.blue,  s2_v2_q);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= hsv_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Payload registers of all three stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rgb_q   <= map_rgb;
      s1_floor_q <= floor_d;
      s1_sat_q   <= hsv_i.saturation;
      s1_sfull_q <= (hsv_i.saturation == K255);
      s1_v2_q    <= v2_d;
      s1_vfull_q <= (hsv_i.brightness == K255);
      s2_rgb_q   <= s2_rgb_d;
      s2_v2_q    <= s1_v2_q;
      s2_vfull_q <= s1_vfull_q;
      s3_rgb_q   <= s3_rgb_d;
    end
  end

  assign rgb_o.valid = s3_valid_q;
  assign rgb_o.red   = s3_rgb_q.red;
  assign rgb_o.green = s3_rgb_q.green;
  assign rgb_o.blue  = s3_rgb_q.blue;

`ifndef SYNTHESIS
  // A held result blocks new items.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rgb_o.valid && !rgb_o.ready) |-> !hsv_i.ready)
    else $error("input accepted while output stalled");

  // An item in stage one reaches stage two when the pipe advances.
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> s2_valid_q)
    else $error("item lost between stage one and stage two");

  // An item in stage two reaches the output when the pipe advances.
  a_s2_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q) |=> rgb_o.valid)
    else $error("item lost between stage two and output");

  // Zero brightness gives black.
  a_zero_val_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q && !s2_vfull_q && (s2_v2_q == 8'd0))
    |=> (rgb_o.red == 8'd0 && rgb_o.green == 8'd0 && rgb_o.blue == 8'd0))
    else $error("zero brightness did not give black");
`endif

endmodule

`default_nettype wire

@@ verif/hsv_to_rgb_rainbow_checker.sv @@
// Checker that predicts every converted pixel of the rainbow HSV to RGB block and compares it.
module hsv_to_rgb_rainbow_checker
  import hsvr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvr_hsv_if         hsv_mon,
  hsvr_rgb_if         rgb_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned in_flight_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One pixel on its way through the block: the input triple and the color it must become.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
    rgb_t       color;
  } pixel_expect_t;

  pixel_expect_t color_expect_q[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   in_flight = 0;
  int unsigned   checked = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign in_flight_o    = in_flight;
  assign checked_o      = checked;

  // Upper byte of the product of two bytes.
  function automatic logic [7:0] prod_hi(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] full;
    full = {8'd0, a} * {8'd0, b};
    return full[15:8];
  endfunction

  // Scale a channel so that a nonzero channel never drops to zero under a nonzero scale.
  function automatic logic [7:0] scale_keep(input logic [7:0] chan, input logic [7:0] scale);
    if (chan == 8'd0) begin
      return 8'd0;
    end
    return prod_hi(chan, scale) + {7'd0, scale != 8'd0};
  endfunction

  // Color that the block must produce for one hue, saturation and brightness triple.
  function automatic rgb_t predict_color(input logic [7:0] hue, input logic [7:0] sat,
                                         input logic [7:0] bri);
    logic [7:0] ramp_pos;
    logic [7:0] third;
    logic [7:0] two_thirds;
    logic [7:0] floor_add;
    logic [7:0] bri_sq;
    hue_sec_e   section;
    rgb_t       pix;
    ramp_pos   = {hue[4:0], 3'b000};
    third      = prod_hi(ramp_pos, OneThird);
    two_thirds = prod_hi(ramp_pos, TwoThirds);
    section    = hue_sec_e'(hue[7:5]);

    // Rainbow hue map, with the yellow sections lifted.
    case (section)
      SecRedOrange:  pix = '{K255 - third, third, 8'd0};
      SecOrangeYel:  pix = '{K171, K85 + third, 8'd0};
      SecYelGreen:   pix = '{K171 - two_thirds, K171 + third, 8'd0};
      SecGreenAqua:  pix = '{8'd0, K255 - third, third};
      SecAquaBlue:   pix = '{8'd0, K171 - two_thirds, K85 + two_thirds};
      SecBluePurple: pix = '{third, 8'd0, K255 - third};
      SecPurplePink: pix = '{K85 + third, 8'd0, K171 - third};
      default:       pix = '{K171 + third, 8'd0, K85 - third};
    endcase

    // Partial saturation scales the channels and lifts them by a squared floor that wraps.
    if (sat != K255) begin
      floor_add = prod_hi(K255 - sat, K255 - sat);
      pix.red   = scale_keep(pix.red, sat) + floor_add;
      pix.green = scale_keep(pix.green, sat) + floor_add;
      pix.blue  = scale_keep(pix.blue, sat) + floor_add;
    end

    // Partial brightness scales by the squared brightness.
    if (bri != K255) begin
      bri_sq    = prod_hi(bri, bri) + {7'd0, bri != 8'd0};
      pix.red   = scale_keep(pix.red, bri_sq);
      pix.green = scale_keep(pix.green, bri_sq);
      pix.blue  = scale_keep(pix.blue, bri_sq);
    end
    return pix;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Compare each result item with the oldest waiting pixel, then record new input items.
  always @(posedge clk_i) begin : color_scoreboard
    pixel_expect_t want;
    if (rst_ni) begin
      if (rgb_mon.valid && rgb_mon.ready) begin
        if (color_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d,%0d,%0d with no pixel waiting",
                                    rgb_mon.red, rgb_mon.green, rgb_mon.blue));
        end else begin
          want = color_expect_q.pop_front();
          checked++;
          if (rgb_mon.red !== want.color.red) begin
            report_mismatch($sformatf("hsv %0d,%0d,%0d red got %0d expected %0d",
                                      want.hue, want.sat, want.bri, rgb_mon.red,
                                      want.color.red));
          end
          if (rgb_mon.green !== want.color.green) begin
            report_mismatch($sformatf("hsv %0d,%0d,%0d green got %0d expected %0d",
                                      want.hue, want.sat, want.bri, rgb_mon.green,
                                      want.color.green));
          end
          if (rgb_mon.blue !== want.color.blue) begin
            report_mismatch($sformatf("hsv %0d,%0d,%0d blue got %0d expected %0d",
                                      want.hue, want.sat, want.bri, rgb_mon.blue,
                                      want.color.blue));
          end
        end
      end
      if (hsv_mon.valid && hsv_mon.ready) begin
        color_expect_q.push_back('{hsv_mon.hue, hsv_mon.saturation, hsv_mon.brightness,
                                   predict_color(hsv_mon.hue, hsv_mon.saturation,
                                                 hsv_mon.brightness)});
      end
      in_flight <= color_expect_q.size();
    end
  end

endmodule

@@ verif/hsv_to_rgb_rainbow_top_tb.sv @@
// Testbench top for the rainbow HSV to RGB converter: clock, reset, stimulus and verdict.
module hsv_to_rgb_rainbow_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvr_pkg::*;

  localparam int unsigned RandomPixels = 1200;
  localparam int unsigned StallLimit   = 2000;

  logic        clk_i;
  logic        rst_ni;
  bit          calm = 1'b0;
  int unsigned mismatch_cnt;
  int unsigned in_flight;
  int unsigned checked;
  int unsigned idle_cycles = 0;

  hsvr_hsv_if hsv_ch();
  hsvr_rgb_if rgb_ch();

  hsv_to_rgb_rainbow_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv_ch),
    .rgb_o  (rgb_ch)
  );

  hsv_to_rgb_rainbow_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hsv_mon        (hsv_ch),
    .rgb_mon        (rgb_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .in_flight_o    (in_flight),
    .checked_o      (checked)
  );

  // 50 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls about one cycle in ten, except during the calm stretch.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rgb_ch.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // Stop the run when no item has moved on either channel for too long.
  always @(posedge clk_i) begin
    if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Watchdog: no item moved for %0d cycles", StallLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one pixel after an optional random gap and hold it until the block takes it.
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] bri);
    while (!calm && $urandom_range(99) < 10) begin
      hsv_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    hsv_ch.valid      <= 1'b1;
    hsv_ch.hue        <= hue;
    hsv_ch.saturation <= sat;
    hsv_ch.brightness <= bri;
    @(posedge clk_i);
    while (!hsv_ch.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Saturation or brightness level, weighted toward the full, zero and near-end values.
  function automatic logic [7:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      return 8'd255;
    end
    if (roll < 25) begin
      return 8'd0;
    end
    if (roll < 30) begin
      return 8'd254;
    end
    if (roll < 35) begin
      return 8'd1;
    end
    return 8'($urandom_range(255));
  endfunction

  // Reset, directed pixels, random pixels, drain and verdict.
  initial begin
    hue_sec_e sec;
    rst_ni            = 1'b0;
    hsv_ch.valid      = 1'b0;
    hsv_ch.hue        = 8'd0;
    hsv_ch.saturation = 8'd0;
    hsv_ch.brightness = 8'd0;
    rgb_ch.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Both ends of every hue section at full saturation and brightness.
    sec = sec.first();
    do begin
      send_pixel({sec, 5'd0}, 8'd255, 8'd255);
      send_pixel({sec, 5'd31}, 8'd255, 8'd255);
      sec = sec.next();
    end while (sec != sec.first());

    // Saturation and brightness extremes, and a mixed case where the floor is added.
    send_pixel(8'd20, 8'd0, 8'd255);
    send_pixel(8'd100, 8'd1, 8'd255);
    send_pixel(8'd200, 8'd254, 8'd255);
    send_pixel(8'd60, 8'd255, 8'd0);
    send_pixel(8'd140, 8'd255, 8'd1);
    send_pixel(8'd230, 8'd255, 8'd254);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd16, 8'd128);

    // Random pixels, with a stretch of back-to-back traffic in the middle.
    for (int unsigned i = 0; i < RandomPixels; i++) begin
      calm <= (i >= 500) && (i < 800);
      send_pixel(8'($urandom_range(255)), pick_level(), pick_level());
    end
    hsv_ch.valid <= 1'b0;
    calm         <= 1'b0;

    // Wait for every result, then keep the clock running for stray items.
    while (in_flight != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Checked %0d pixels: both ends of all hue sections, saturation and brightness",
             checked);
    $display("extremes, then random triples under random stalls on both channels.");
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
